// File: hdl/assert_macros.svh
// Assertion macros shared by the refresh sequencer modules.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define OPRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("oprs check failed");

// Check that a condition implies another in the next cycle.
`define OPRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("oprs check failed");

`endif

// File: hdl/oprs_pkg.sv
// Package for the page refresh sequencer: geometry, command codes, types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package oprs_pkg;

    // Display geometry and chunking
    localparam int WIDTH       = 128;
    localparam int PAGES       = 4;
    localparam int MAX_CHUNK   = 32;

    // Frame store: two buffers of 512 bytes
    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = 10;
    localparam int BUF_AW      = 9;

    localparam int COL_W       = $clog2(WIDTH + 1);
    localparam int PAGE_W      = 3;
    localparam int CNT_W       = $clog2(MAX_CHUNK + 1);
    localparam int INIT_COUNT  = 25;
    localparam int INIT_W      = 5;

    // Item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_SHOW  = 2'd2;

    // Command bytes and register resets
    localparam logic [7:0] CMD_PAGE      = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [6:0] DEV_ADDR_RST  = 7'h3C;
    localparam logic [5:0] CHUNK_LEN_RST = 6'd32;

    typedef enum logic [2:0] {
        PH_INIT,
        PH_IDLE,
        PH_PAGE,
        PH_COL_LOW,
        PH_COL_HIGH,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_ACCEPT,
        ST_TICK,
        ST_DATA
    } seq_state_t;

    // One result handed from the sequencer to the output stages
    typedef struct packed {
        logic       valid;
        logic       from_mem;
        logic       is_data;
        logic       last;
        logic [7:0] cmd;
    } issue_t;

    // Controller power-up command list
    function automatic logic [7:0] init_byte(input logic [INIT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'hAE;
            5'd1:    b = 8'hD5;
            5'd2:    b = 8'h80;
            5'd3:    b = 8'hA8;
            5'd4:    b = 8'h1F;
            5'd5:    b = 8'hD3;
            5'd6:    b = 8'h00;
            5'd7:    b = 8'h40;
            5'd8:    b = 8'h8D;
            5'd9:    b = 8'h14;
            5'd10:   b = 8'h20;
            5'd11:   b = 8'h00;
            5'd12:   b = 8'hA1;
            5'd13:   b = 8'hC8;
            5'd14:   b = 8'hDA;
            5'd15:   b = 8'h02;
            5'd16:   b = 8'h81;
            5'd17:   b = 8'h8F;
            5'd18:   b = 8'hD9;
            5'd19:   b = 8'hF1;
            5'd20:   b = 8'hDB;
            5'd21:   b = 8'h40;
            5'd22:   b = 8'hA4;
            5'd23:   b = 8'hA6;
            5'd24:   b = 8'hAF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/oprs_frame_mem.sv
// Frame store for both buffers: one write port, one registered read port.
// Depends on oprs_pkg for the store geometry.
`timescale 1ns / 1ps

module oprs_frame_mem (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [oprs_pkg::STORE_AW-1:0] waddr,
    input  logic [7:0]                    wdata,
    input  logic                          re,
    input  logic [oprs_pkg::STORE_AW-1:0] raddr,
    output logic [7:0]                    rdata
);

    logic [7:0] store_mem [oprs_pkg::STORE_DEPTH];
    logic [7:0] rdata_reg;

    // Write one byte
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
    end

    // Read one byte; hold the last read while idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/oprs_emit.sv
// Result stages: memory-read stage followed by the output register.
// Depends on oprs_pkg (issue_t) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oprs_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  oprs_pkg::issue_t     issue,
    input  logic [7:0]           rdata,
    input  logic [6:0]           link_addr,
    output logic                 slot_free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // target_address[6:0], payload[14:7], zero[15]
    output logic                 m_tuser,   // is_data
    output logic                 m_tlast
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    oprs_pkg::issue_t s1_info_reg;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [6:0]       m_addr_reg;
    logic [7:0]       m_payload_reg;
    logic             m_is_data_reg;
    logic             m_last_reg;
    logic             out_load;

    // Move stage one into the output register when it is empty or drained
    assign out_load  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign slot_free = !s1_valid_reg || out_load;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (issue.valid) begin
            s1_valid_next = 1'b1;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (issue.valid) begin
            s1_info_reg <= issue;
        end
        if (out_load) begin
            m_addr_reg    <= link_addr;
            m_payload_reg <= s1_info_reg.from_mem ? rdata : s1_info_reg.cmd;
            m_is_data_reg <= s1_info_reg.is_data;
            m_last_reg    <= s1_info_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_payload_reg, m_addr_reg};
    assign m_tuser  = m_is_data_reg;
    assign m_tlast  = m_last_reg;

    `OPRS_ASSERT_SAME(a_issue_has_slot, aclk, aresetn, issue.valid, slot_free)
    `OPRS_ASSERT_NEXT(a_s1_holds, aclk, aresetn, s1_valid_reg && !out_load, s1_valid_reg)

endmodule

// File: hdl/oprs_ctrl.sv
// Refresh sequencer: takes items, walks init, page commands and data chunks,
// and drives the frame store ports. Depends on oprs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oprs_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind,
    input  logic                          s_link_ready,
    input  logic                          s_buffer_select,
    input  logic [oprs_pkg::BUF_AW-1:0]   s_byte_address,
    input  logic [7:0]                    s_byte_value,
    input  logic [5:0]                    chunk_length,
    input  logic                          slot_free,
    output oprs_pkg::issue_t              issue,
    output logic                          mem_we,
    output logic [oprs_pkg::STORE_AW-1:0] mem_waddr,
    output logic [7:0]                    mem_wdata,
    output logic                          mem_re,
    output logic [oprs_pkg::STORE_AW-1:0] mem_raddr
);

    localparam int CW = oprs_pkg::COL_W;
    localparam int PW = oprs_pkg::PAGE_W;
    localparam int NW = oprs_pkg::CNT_W;
    localparam int IW = oprs_pkg::INIT_W;
    localparam int AW = oprs_pkg::STORE_AW;

    oprs_pkg::seq_state_t state_reg, state_next;
    oprs_pkg::phase_t     phase_reg, phase_next;
    logic [IW-1:0]        init_pos_reg, init_pos_next;
    logic [PW-1:0]        page_reg, page_next;
    logic [CW-1:0]        col_reg, col_next;
    logic                 active_reg, active_next;
    logic                 req_reg, req_next;
    logic                 wait_buf_reg, wait_buf_next;
    logic                 link_ready_reg, link_ready_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [NW-1:0]        cnt_reg, cnt_next;

    // Tick resolution
    oprs_pkg::phase_t     t_phase;
    logic                 t_active;
    logic                 t_req;
    logic [PW-1:0]        t_page;
    logic [CW-1:0]        t_col;
    logic                 t_emit;
    logic [7:0]           t_cmd;
    logic                 t_init_adv;
    logic                 t_data;
    logic                 t_skip;
    logic                 t_start;

    logic                 accept;
    logic [NW-1:0]        limit;
    logic [CW-1:0]        avail;
    logic [NW-1:0]        count;
    logic [CW-1:0]        col_inc;
    logic [PW:0]          page_inc;
    logic [AW-1:0]        rd_addr;

    assign s_ready = (state_reg == oprs_pkg::ST_ACCEPT);
    assign accept  = s_valid && s_ready;

    // Clamp chunk length to 1 .. MAX_CHUNK and bound it by the rest of the page
    always_comb begin
        if (chunk_length == 6'd0) begin
            limit = NW'(1);
        end else if (int'(chunk_length) > oprs_pkg::MAX_CHUNK) begin
            limit = NW'(oprs_pkg::MAX_CHUNK);
        end else begin
            limit = NW'(chunk_length);
        end
        avail = CW'(oprs_pkg::WIDTH) - col_reg;
        count = (int'(avail) > int'(limit)) ? limit : NW'(avail);
    end

    assign col_inc  = col_reg + CW'(1);
    assign page_inc = {1'b0, page_reg} + (PW + 1)'(1);
    assign rd_addr  = {active_reg, {oprs_pkg::BUF_AW{1'b0}}}
                    + AW'(page_reg * oprs_pkg::WIDTH) + AW'(col_reg);

    // Resolve what a tick does from the stored phase
    always_comb begin
        t_phase    = phase_reg;
        t_active   = active_reg;
        t_req      = req_reg;
        t_page     = page_reg;
        t_col      = col_reg;
        t_emit     = 1'b0;
        t_cmd      = oprs_pkg::CMD_COL_LOW;
        t_init_adv = 1'b0;
        t_data     = 1'b0;
        t_skip     = 1'b0;
        t_start    = 1'b0;
        if (phase_reg == oprs_pkg::PH_INIT) begin
            if (init_pos_reg < IW'(oprs_pkg::INIT_COUNT)) begin
                t_skip = 1'b1;
                if (link_ready_reg) begin
                    t_emit     = 1'b1;
                    t_cmd      = oprs_pkg::init_byte(init_pos_reg);
                    t_init_adv = 1'b1;
                end
            end else if (req_reg) begin
                t_start = 1'b1;
            end else begin
                t_phase = oprs_pkg::PH_IDLE;
            end
        end
        if (!t_skip && t_phase == oprs_pkg::PH_IDLE) begin
            if (req_reg) begin
                t_start = 1'b1;
            end else begin
                t_skip = 1'b1;
            end
        end
        if (t_start) begin
            t_active = wait_buf_reg;
            t_req    = 1'b0;
            t_page   = '0;
            t_col    = '0;
            t_phase  = oprs_pkg::PH_PAGE;
        end
        if (!t_skip && link_ready_reg) begin
            case (t_phase)
                oprs_pkg::PH_PAGE: begin
                    t_emit  = 1'b1;
                    t_cmd   = oprs_pkg::CMD_PAGE | {{(8 - PW){1'b0}}, t_page};
                    t_phase = oprs_pkg::PH_COL_LOW;
                end
                oprs_pkg::PH_COL_LOW: begin
                    t_emit  = 1'b1;
                    t_cmd   = oprs_pkg::CMD_COL_LOW;
                    t_phase = oprs_pkg::PH_COL_HIGH;
                end
                oprs_pkg::PH_COL_HIGH: begin
                    t_emit  = 1'b1;
                    t_cmd   = oprs_pkg::CMD_COL_HIGH;
                    t_phase = oprs_pkg::PH_DATA;
                end
                oprs_pkg::PH_DATA: begin
                    t_data = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            oprs_pkg::ST_CLEAR: begin
                if (clr_addr_reg == {AW{1'b1}}) begin
                    state_next = oprs_pkg::ST_ACCEPT;
                end
            end
            oprs_pkg::ST_ACCEPT: begin
                if (accept && s_kind == oprs_pkg::KIND_TICK) begin
                    state_next = oprs_pkg::ST_TICK;
                end
            end
            oprs_pkg::ST_TICK: begin
                if (t_data) begin
                    state_next = oprs_pkg::ST_DATA;
                end else if (!t_emit || slot_free) begin
                    state_next = oprs_pkg::ST_ACCEPT;
                end
            end
            oprs_pkg::ST_DATA: begin
                if (slot_free && cnt_reg == NW'(1)) begin
                    state_next = oprs_pkg::ST_ACCEPT;
                end
            end
            default: begin
                state_next = oprs_pkg::ST_ACCEPT;
            end
        endcase
    end

    // Datapath and memory port outputs
    always_comb begin
        phase_next      = phase_reg;
        init_pos_next   = init_pos_reg;
        page_next       = page_reg;
        col_next        = col_reg;
        active_next     = active_reg;
        req_next        = req_reg;
        wait_buf_next   = wait_buf_reg;
        link_ready_next = link_ready_reg;
        clr_addr_next   = clr_addr_reg;
        cnt_next        = cnt_reg;
        issue           = '0;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = 8'h00;
        mem_re          = 1'b0;
        mem_raddr       = rd_addr;
        unique case (state_reg)
            oprs_pkg::ST_CLEAR: begin
                // Sweep the store with zeros, one entry a cycle
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            oprs_pkg::ST_ACCEPT: begin
                if (accept) begin
                    case (s_kind)
                        oprs_pkg::KIND_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = {s_buffer_select, s_byte_address};
                            mem_wdata = s_byte_value;
                        end
                        oprs_pkg::KIND_SHOW: begin
                            wait_buf_next = s_buffer_select;
                            req_next      = 1'b1;
                            if (phase_reg == oprs_pkg::PH_IDLE) begin
                                active_next = s_buffer_select;
                                req_next    = 1'b0;
                                page_next   = '0;
                                col_next    = '0;
                                phase_next  = oprs_pkg::PH_PAGE;
                            end
                        end
                        oprs_pkg::KIND_TICK: begin
                            link_ready_next = s_link_ready;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            oprs_pkg::ST_TICK: begin
                // Commit unless a command must wait for a free result slot
                if (!t_emit || slot_free) begin
                    phase_next  = t_phase;
                    active_next = t_active;
                    req_next    = t_req;
                    page_next   = t_page;
                    col_next    = t_col;
                    if (t_init_adv) begin
                        init_pos_next = init_pos_reg + IW'(1);
                    end
                    if (t_data) begin
                        cnt_next = count;
                    end
                    issue.valid   = t_emit;
                    issue.from_mem = 1'b0;
                    issue.is_data = 1'b0;
                    issue.last    = 1'b1;
                    issue.cmd     = t_cmd;
                end
            end
            oprs_pkg::ST_DATA: begin
                // Read one pixel byte a cycle while a result slot is free and advance the column
                if (slot_free) begin
                    mem_re         = 1'b1;
                    issue.valid    = 1'b1;
                    issue.from_mem = 1'b1;
                    issue.is_data  = 1'b1;
                    issue.last     = (cnt_reg == NW'(1));
                    cnt_next       = cnt_reg - NW'(1);
                    col_next       = col_inc;
                    if (cnt_reg == NW'(1) && col_inc == CW'(oprs_pkg::WIDTH)) begin
                        col_next = '0;
                        if (int'(page_inc) >= oprs_pkg::PAGES) begin
                            page_next  = '0;
                            phase_next = oprs_pkg::PH_IDLE;
                        end else begin
                            page_next  = page_inc[PW-1:0];
                            phase_next = oprs_pkg::PH_PAGE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= oprs_pkg::ST_CLEAR;
            phase_reg    <= oprs_pkg::PH_INIT;
            init_pos_reg <= '0;
            page_reg     <= '0;
            col_reg      <= '0;
            active_reg   <= 1'b0;
            req_reg      <= 1'b1;
            wait_buf_reg <= 1'b0;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            init_pos_reg <= init_pos_next;
            page_reg     <= page_next;
            col_reg      <= col_next;
            active_reg   <= active_next;
            req_reg      <= req_next;
            wait_buf_reg <= wait_buf_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        link_ready_reg <= link_ready_next;
        cnt_reg        <= cnt_next;
    end

    // Reads happen only in ST_DATA and writes never there, so no forwarding is needed
    `OPRS_ASSERT_SAME(a_no_rw_overlap, aclk, aresetn, mem_re, !mem_we)
    `OPRS_ASSERT_SAME(a_data_phase, aclk, aresetn, state_reg == oprs_pkg::ST_DATA, phase_reg == oprs_pkg::PH_DATA)
    `OPRS_ASSERT_SAME(a_data_count, aclk, aresetn, state_reg == oprs_pkg::ST_DATA, cnt_reg != '0)

endmodule

// File: hdl/oled_page_refresh_sequencer.sv
// Top level of the page refresh sequencer: APB registers, sequencer,
// frame store and result stages. Depends on oprs_pkg and the oprs_* modules.
//
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  tuser: kind, buffer_select; tdata: link_ready, address, byte
// m_*       out  m_tvalid/m_tready  tuser: is_data; tdata: target_address, payload; tlast
// apb       in   psel/penable       bus address at 0x0, chunk length at 0x4
//
// Steps: a write or show item is taken in ST_ACCEPT; a tick then passes through ST_TICK, and through
// ST_DATA as well for a chunk of pixel bytes, one frame store read per cycle while a result slot is free.
// Issued results pass through the stage-one register and the output register on their way to m_*.
// Reset: a clearing pass zeroes the frame store with s_tready low.
// Stalls: m_tready low holds the result stages; the sequencer waits for a free slot.
`timescale 1ns / 1ps

module oled_page_refresh_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // link_ready[0], byte_address[9:1], byte_value[17:10], zero
    input  logic [2:0]  s_tuser,   // kind[1:0], buffer_select[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // target_address[6:0], payload[14:7], zero[15]
    output logic        m_tuser,   // is_data
    output logic        m_tlast,   // last_byte
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_DEVICE_ADDR = 1'b0;
    localparam logic REG_CHUNK_LEN   = 1'b1;

    logic [6:0]                    dev_addr_reg;
    logic [6:0]                    dev_addr_next;
    logic [5:0]                    chunk_len_reg;
    logic [5:0]                    chunk_len_next;
    logic                          cfg_write;
    oprs_pkg::issue_t              issue;
    logic                          slot_free;
    logic                          mem_we;
    logic [oprs_pkg::STORE_AW-1:0] mem_waddr;
    logic [7:0]                    mem_wdata;
    logic                          mem_re;
    logic [oprs_pkg::STORE_AW-1:0] mem_raddr;
    logic [7:0]                    mem_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Decode register writes
    always_comb begin
        dev_addr_next  = dev_addr_reg;
        chunk_len_next = chunk_len_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_DEVICE_ADDR: dev_addr_next  = pwdata[6:0];
                REG_CHUNK_LEN:   chunk_len_next = pwdata[5:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_DEVICE_ADDR: prdata = 32'(dev_addr_reg);
            REG_CHUNK_LEN:   prdata = 32'(chunk_len_reg);
            default:         prdata = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg  <= oprs_pkg::DEV_ADDR_RST;
            chunk_len_reg <= oprs_pkg::CHUNK_LEN_RST;
        end else begin
            dev_addr_reg  <= dev_addr_next;
            chunk_len_reg <= chunk_len_next;
        end
    end

    oprs_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_tvalid),
        .s_ready         (s_tready),
        .s_kind          (s_tuser[1:0]),
        .s_link_ready    (s_tdata[0]),
        .s_buffer_select (s_tuser[2]),
        .s_byte_address  (s_tdata[9:1]),
        .s_byte_value    (s_tdata[17:10]),
        .chunk_length    (chunk_len_reg),
        .slot_free       (slot_free),
        .issue           (issue),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr)
    );

    oprs_frame_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    oprs_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .rdata     (mem_rdata),
        .link_addr (dev_addr_reg),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: test/tb.sv
// Self-checking bench for oled_page_refresh_sequencer: drives framebuffer writes, show requests
// and link ticks, predicts every link byte and checks them in order. Depends on oprs_pkg.
`timescale 1ns / 1ps

module tb;
    import oprs_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic [2:0] REG_DEV_ADDR  = 3'd0;
    localparam logic [2:0] REG_CHUNK_LEN = 3'd4;
    localparam int BUF_BYTES      = 512;
    localparam int STORE_MASK     = 1023;
    localparam int SETTLE_CYCLES  = 50;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT    = 3000;

    // Controller power-up commands, first byte in the lowest bits
    localparam logic [25*8-1:0] POWER_UP_CMDS = {
        8'hAF, 8'hA6, 8'hA4, 8'h40, 8'hDB, 8'hF1, 8'hD9, 8'h8F, 8'h81, 8'h02,
        8'hDA, 8'hC8, 8'hA1, 8'h00, 8'h20, 8'h14, 8'h8D, 8'h40, 8'h00, 8'hD3,
        8'h1F, 8'hA8, 8'h80, 8'hD5, 8'hAE
    };

    typedef struct packed {
        logic [1:0] kind;
        logic       link_ok;
        logic       sel;
        logic [8:0] addr;
        logic [7:0] val;
    } display_item_t;

    typedef struct packed {
        logic [6:0] target;
        logic       is_data;
        logic [7:0] payload;
        logic       last;
    } link_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // link_ready[0], byte_address[9:1], byte_value[17:10], zero
    logic [2:0]  s_tuser  = '0;   // kind[1:0], buffer_select[2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // target_address[6:0], payload[14:7], zero[15]
    logic        m_tuser;         // is_data
    logic        m_tlast;         // last_byte
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    oled_page_refresh_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the display controller state
    logic [6:0] dev_addr_cfg;
    logic [5:0] chunk_cfg;
    phase_t     disp_phase;
    int         init_idx;
    logic [2:0] page_idx;
    int         col_idx;
    logic       shown_buf;
    logic       refresh_due;
    logic       due_buf;
    logic [7:0] pixel_mem [0:1023];

    display_item_t pending_items [$];
    link_byte_t    expected_bytes [$];
    display_item_t held_item;
    int items_sent = 0;
    int items_done = 0;
    int error_count = 0;
    int tx_gap = 0;
    int rx_wait = 0;
    int rx_hold_left = 0;
    int rx_hold_asked = 0;
    int rx_hold_served = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    function automatic void expect_byte(logic is_data, logic [7:0] payload, logic last);
        expected_bytes.push_back({dev_addr_cfg, is_data, payload, last});
    endfunction

    function automatic void start_page_refresh();
        shown_buf   = due_buf;
        refresh_due = 1'b0;
        page_idx    = '0;
        col_idx     = 0;
        disp_phase  = PH_PAGE;
    endfunction

    // One tick: at most one link transaction, a data chunk giving one or more bytes
    function automatic void predict_tick(logic link_ok);
        int limit;
        int count;
        int base;
        if (disp_phase == PH_INIT) begin
            if (init_idx < INIT_COUNT) begin
                if (link_ok) begin
                    expect_byte(1'b0, POWER_UP_CMDS[init_idx*8 +: 8], 1'b1);
                    init_idx++;
                end
                return;
            end
            if (refresh_due) start_page_refresh();
            else disp_phase = PH_IDLE;
        end
        if (disp_phase == PH_IDLE) begin
            if (!refresh_due) return;
            start_page_refresh();
        end
        if (!link_ok) return;
        case (disp_phase)
            PH_PAGE: begin
                expect_byte(1'b0, CMD_PAGE | {5'd0, page_idx}, 1'b1);
                disp_phase = PH_COL_LOW;
            end
            PH_COL_LOW: begin
                expect_byte(1'b0, CMD_COL_LOW, 1'b1);
                disp_phase = PH_COL_HIGH;
            end
            PH_COL_HIGH: begin
                expect_byte(1'b0, CMD_COL_HIGH, 1'b1);
                disp_phase = PH_DATA;
            end
            PH_DATA: begin
                // a zero length counts as one, anything past the maximum saturates
                limit = int'(chunk_cfg);
                if (limit == 0) limit = 1;
                if (limit > MAX_CHUNK) limit = MAX_CHUNK;
                count = (col_idx < WIDTH) ? WIDTH - col_idx : 0;
                if (count > limit) count = limit;
                base = (shown_buf ? BUF_BYTES : 0) + page_idx * WIDTH + col_idx;
                for (int i = 0; i < count; i++) begin
                    expect_byte(1'b1, pixel_mem[(base + i) & STORE_MASK], i == count - 1);
                end
                col_idx += count;
                if (col_idx >= WIDTH) begin
                    col_idx = 0;
                    page_idx++;
                    if (page_idx >= PAGES) begin
                        page_idx   = '0;
                        disp_phase = PH_IDLE;
                    end else begin
                        disp_phase = PH_PAGE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_display_item(display_item_t it);
        case (it.kind)
            KIND_WRITE: pixel_mem[{it.sel, it.addr}] = it.val;
            KIND_SHOW: begin
                // a newer request replaces the one waiting
                due_buf     = it.sel;
                refresh_due = 1'b1;
                if (disp_phase == PH_IDLE) start_page_refresh();
            end
            KIND_TICK: predict_tick(it.link_ok);
            default: ;
        endcase
    endfunction

    function automatic display_item_t make_item(logic [1:0] kind, logic link_ok, logic sel,
                                                logic [8:0] addr, logic [7:0] val);
        display_item_t it;
        it = {kind, link_ok, sel, addr, val};
        return it;
    endfunction

    // Mostly ready ticks, with writes, show requests and the odd unused kind mixed in
    function automatic display_item_t random_item();
        int unsigned roll;
        logic [1:0]  kind;
        roll = $urandom_range(0, 99);
        if (roll < 12) kind = KIND_WRITE;
        else if (roll < 19) kind = KIND_SHOW;
        else if (roll < 22) kind = KIND_UNUSED;
        else kind = KIND_TICK;
        return make_item(kind, $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
                         9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
    endfunction

    // Sender: offer queued items, pausing at random after each
    always @(posedge aclk) begin : stream_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_display_item(held_item);
                items_done = items_done + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (pending_items.size() != 0) begin
                    held_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, held_item.val, held_item.addr, held_item.link_ok};
                    s_tuser  <= {held_item.sel, held_item.kind};
                    tx_gap   <= tx_steady ? 0 : $urandom_range(0, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each link byte against the oldest prediction, stall at random
    always @(posedge aclk) begin : link_monitor
        link_byte_t  got_byte;
        link_byte_t  want_byte;
        int unsigned pause;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_byte = {m_tdata[6:0], m_tuser, m_tdata[14:7], m_tlast};
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected link byte: addr %h data %b byte %h last %b",
                             $time, got_byte.target, got_byte.is_data, got_byte.payload,
                             got_byte.last);
                    error_count++;
                end else begin
                    want_byte = expected_bytes.pop_front();
                    if (got_byte !== want_byte) begin
                        $display({"%0t: link byte mismatch: expected addr %h data %b byte %h ",
                                  "last %b, got addr %h data %b byte %h last %b"},
                                 $time, want_byte.target, want_byte.is_data,
                                 want_byte.payload, want_byte.last, got_byte.target,
                                 got_byte.is_data, got_byte.payload, got_byte.last);
                        error_count++;
                    end
                end
            end
            if (rx_hold_left > 0) begin
                m_tready     <= 1'b0;
                rx_hold_left <= rx_hold_left - 1;
            end else if (rx_hold_served != rx_hold_asked) begin
                // long hold-off so the block backs up into its input
                rx_hold_served <= rx_hold_asked;
                rx_hold_left   <= RX_HOLD_CYCLES;
                m_tready       <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                pause = rx_steady ? 0 : $urandom_range(0, 5);
                rx_wait  <= pause;
                m_tready <= (pause == 0);
            end else if (rx_wait > 0) begin
                rx_wait  <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Give up when no transaction moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("[oled_page_refresh_sequencer] ERROR");
        $finish;
    end

    task automatic queue_item(display_item_t it);
        pending_items.push_back(it);
        items_sent++;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) queue_item(random_item());
    endtask

    // Hold the sender until every item is taken and every link byte seen, then let
    // a tick that gives no byte finish inside the block
    task automatic wait_idle();
        while (items_done != items_sent || expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_DEV_ADDR) dev_addr_cfg = data[6:0];
        else if (addr == REG_CHUNK_LEN) chunk_cfg = data[5:0];
    endtask

    task automatic apply_settings(logic [6:0] dev, logic [5:0] chunk);
        wait_idle();
        apb_write(REG_DEV_ADDR, {25'd0, dev});
        apb_write(REG_CHUNK_LEN, {26'd0, chunk});
    endtask

    initial begin : stimulus
        dev_addr_cfg = DEV_ADDR_RST;
        chunk_cfg    = CHUNK_LEN_RST;
        disp_phase   = PH_INIT;
        init_idx     = 0;
        page_idx     = '0;
        col_idx      = 0;
        shown_buf    = 1'b0;
        refresh_due  = 1'b1;
        due_buf      = 1'b0;
        for (int i = 0; i <= STORE_MASK; i++) pixel_mem[i] = 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored items, buffer corners, page edge, replaced show requests
        queue_item(make_item(KIND_TICK, 1'b0, 1'b0, 9'd0, 8'd0));
        queue_item(make_item(KIND_UNUSED, 1'b1, 1'b1, 9'h1FF, 8'hFF));
        queue_item(make_item(KIND_WRITE, 1'b0, 1'b0, 9'd0, 8'hFF));
        queue_item(make_item(KIND_WRITE, 1'b1, 1'b0, 9'd511, 8'h81));
        queue_item(make_item(KIND_WRITE, 1'b0, 1'b0, 9'd127, 8'h3C));
        queue_item(make_item(KIND_WRITE, 1'b0, 1'b0, 9'd128, 8'hC3));
        queue_item(make_item(KIND_WRITE, 1'b0, 1'b1, 9'd0, 8'h7E));
        queue_item(make_item(KIND_WRITE, 1'b0, 1'b1, 9'd511, 8'hFF));
        queue_item(make_item(KIND_SHOW, 1'b0, 1'b1, 9'd0, 8'd0));
        queue_item(make_item(KIND_SHOW, 1'b1, 1'b0, 9'h1FF, 8'hFF));
        queue_item(make_item(KIND_SHOW, 1'b0, 1'b1, 9'd0, 8'd0));
        queue_random(60);

        // Back-pressure: stop taking link bytes while the sender keeps going
        wait_idle();
        queue_item(make_item(KIND_SHOW, 1'b1, 1'b0, 9'd0, 8'd0));
        queue_random(50);
        rx_hold_asked++;

        apply_settings(7'd127, 6'd1);
        queue_random(40);
        apply_settings(7'd0, 6'd0);
        queue_random(40);
        apply_settings(7'($urandom_range(1, 126)), 6'd63);
        queue_random(40);

        // No idling on either side for this stretch
        apply_settings(7'($urandom_range(1, 126)), 6'd17);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        queue_random(40);
        wait_idle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        apply_settings(DEV_ADDR_RST, 6'd32);
        queue_random(50);

        wait_idle();
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("[oled_page_refresh_sequencer] OK");
        end else begin
            $display("[oled_page_refresh_sequencer] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/oprs_pkg.sv
hdl/oprs_frame_mem.sv
hdl/oprs_emit.sv
hdl/oprs_ctrl.sv
hdl/oled_page_refresh_sequencer.sv
test/tb.sv
